// ----- rtl/teba_pkg.sv -----
// types, element codes and small helpers for the typed element buffer access core
// no dependencies
package teba_pkg;

  localparam logic [3:0] ET_U8   = 4'd0;
  localparam logic [3:0] ET_U8C  = 4'd1;
  localparam logic [3:0] ET_I8   = 4'd2;
  localparam logic [3:0] ET_U16  = 4'd3;
  localparam logic [3:0] ET_I16  = 4'd4;
  localparam logic [3:0] ET_U32  = 4'd5;
  localparam logic [3:0] ET_I32  = 4'd6;
  localparam logic [3:0] ET_F32  = 4'd7;
  localparam logic [3:0] ET_F64  = 4'd8;
  localparam logic [3:0] ET_I64  = 4'd9;
  localparam logic [3:0] ET_U64  = 4'd10;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;
  localparam int QUEUE_DEPTH = 2;
  localparam int LANES = 8;

  typedef struct packed {
    logic        mode;
    logic [3:0]  elem_type;
    logic        little_endian;
    logic [11:0] byte_index;
    logic [63:0] write_bits;
  } teba_in_t;

  typedef struct packed {
    logic [63:0] read_bits;
    logic        range_error;
  } teba_out_t;

  // one classified access waiting for the back end
  typedef struct packed {
    logic        is_write;
    logic        refused;
    logic [3:0]  elem_type;
    logic        little_endian;
    logic [11:0] byte_index;
    logic [63:0] raw;
  } teba_op_t;

  function automatic logic [3:0] elem_size(input logic [3:0] t);
    logic [3:0] n;
    case (t) inside
      ET_U8, ET_U8C, ET_I8:         n = 4'd1;
      ET_U16, ET_I16:               n = 4'd2;
      ET_U32, ET_I32, ET_F32:       n = 4'd4;
      ET_F64, ET_I64, ET_U64:       n = 4'd8;
      default:                      n = 4'd1;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/teba_ram.sv -----
// generic single write port, single read port ram with registered read data
// no dependencies
module teba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/teba_fifo.sv -----
// short queue of classified accesses between front and back end
// depends on teba_pkg
module teba_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  teba_pkg::teba_op_t push_data,
  input  logic              pop,
  output teba_pkg::teba_op_t head,
  output logic              empty,
  output logic              full
);
  import teba_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  teba_op_t       entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) empty |-> !pop)
    else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !empty)
    else $error("queue lost an entry");
endmodule

// ----- rtl/teba_front.sv -----
// front end: bounds and type check, write value conversion, length register
// depends on teba_pkg
module teba_front #(
  parameter int STORE_BYTES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  input  teba_pkg::teba_in_t in_data,
  output teba_pkg::teba_op_t op
);
  import teba_pkg::*;

  localparam int CAP_INT = (STORE_BYTES > 8191) ? 8191 : STORE_BYTES;
  localparam logic [12:0] CAP = 13'(CAP_INT);

  logic [12:0] byte_length;
  logic [12:0] limit;
  logic [13:0] end_pos;
  logic [3:0]  n;
  logic        sign;
  logic [10:0] ex;
  logic [63:0] m;
  logic [31:0] wrap_v;
  logic [7:0]  clamp_v;
  logic [31:0] f32_v;
  logic [63:0] q_clamp;
  logic [63:0] q_f32;
  logic [5:0]  s_f32;

  function automatic logic [63:0] rne_shift(input logic [63:0] v, input logic [5:0] s);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q    = v >> s;
    half = 64'd1 << (s - 6'd1);
    rem  = v & ((64'd1 << s) - 64'd1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_length <= CAP;
    end else if (cfg_we) begin
      byte_length <= cfg_wdata;
    end
  end

  assign limit   = (byte_length < CAP) ? byte_length : CAP;
  assign n       = elem_size(in_data.elem_type);
  assign end_pos = {2'b00, in_data.byte_index} + {10'd0, n};

  assign sign = in_data.write_bits[63];
  assign ex   = in_data.write_bits[62:52];
  assign m    = {11'd0, 1'b1, in_data.write_bits[51:0]};

  // truncate toward zero, keep the low word, then negate
  always_comb begin
    wrap_v = '0;
    if (ex != 11'h7FF && ex >= 11'd1023) begin
      if (ex <= 11'd1075) begin
        wrap_v = 32'(m >> 6'(11'd1075 - ex));
      end else if (ex < 11'd1107) begin
        wrap_v = 32'(m << 5'(ex - 11'd1075));
      end
    end
    if (sign) begin
      wrap_v = 32'd0 - wrap_v;
    end
  end

  assign q_clamp = rne_shift(m, 6'(11'd1075 - ex));

  always_comb begin
    if ((ex == 11'h7FF && in_data.write_bits[51:0] != '0) || sign) begin
      clamp_v = 8'd0;
    end else if (ex >= 11'd1031) begin
      clamp_v = 8'd255;
    end else if (ex < 11'd1022) begin
      clamp_v = 8'd0;
    end else if (q_clamp > 64'd255) begin
      clamp_v = 8'd255;
    end else begin
      clamp_v = 8'(q_clamp);
    end
  end

  // subnormal targets shift further right
  assign s_f32 = (ex >= 11'd897) ? 6'd29 : 6'(11'd926 - ex);
  assign q_f32 = rne_shift(m, s_f32);

  always_comb begin
    logic [31:0] r;
    r = '0;
    if (ex == 11'h7FF) begin
      if (in_data.write_bits[51:0] == '0) begin
        f32_v = {sign, 31'h7F80_0000};
      end else begin
        f32_v = {sign, 31'h7FC0_0000 | 31'(in_data.write_bits[51:29])};
      end
    end else if (ex == 11'd0 || ex < 11'd863) begin
      f32_v = {sign, 31'd0};
    end else if (ex > 11'd1150) begin
      f32_v = {sign, 31'h7F80_0000};
    end else begin
      if (ex >= 11'd897) begin
        r = (32'(ex - 11'd897) << 23) + 32'(q_f32);
      end else begin
        r = 32'(q_f32);
      end
      if (r >= 32'h7F80_0000) begin
        r = 32'h7F80_0000;
      end
      f32_v = {sign, r[30:0]};
    end
  end

  always_comb begin
    op.is_write      = in_data.mode;
    op.refused       = (in_data.elem_type > ET_U64) || (end_pos > {1'b0, limit});
    op.elem_type     = in_data.elem_type;
    op.little_endian = in_data.little_endian;
    op.byte_index    = in_data.byte_index;
    case (in_data.elem_type) inside
      ET_U8C:                 op.raw = {56'd0, clamp_v};
      ET_F32:                 op.raw = {32'd0, f32_v};
      ET_F64, ET_I64, ET_U64: op.raw = in_data.write_bits;
      default:                op.raw = {32'd0, wrap_v};
    endcase
  end
endmodule

// ----- rtl/teba_back.sv -----
// back end: store banks, clearing pass, byte lane steering and read conversion
// depends on teba_pkg and teba_ram
module teba_back #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  teba_pkg::teba_op_t  head,
  input  logic                empty,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  logic                out_stall,
  output teba_pkg::teba_out_t out_data
);
  import teba_pkg::*;

  localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_READ  = 4'b0100,
    S_CONV  = 4'b1000
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] clr_row;
  teba_op_t         op;
  logic [63:0]      rd_raw;
  logic             rd_sign;
  logic [31:0]      rd_mag;
  logic [4:0]       rd_lz;
  logic             out_free;

  logic [ROW_W-1:0] bank_row  [LANES];
  logic             bank_we   [LANES];
  logic [ROW_W-1:0] bank_waddr[LANES];
  logic [7:0]       bank_wdata[LANES];
  logic [7:0]       bank_rdata[LANES];

  logic [63:0] asm_raw;
  logic        asm_sign;
  logic [31:0] asm_mag;
  logic [4:0]  asm_lz;
  logic [31:0] norm;
  logic [63:0] conv;
  logic [3:0]  hn;
  logic [3:0]  on;

  assign out_free = !out_valid || !out_stall;
  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && !empty && out_free;
  assign hn       = elem_size(head.elem_type);
  assign on       = elem_size(op.elem_type);

  // bank b holds the bytes whose index mod 8 is b
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      logic [2:0] lane;
      logic [2:0] sh;
      lane = 3'(b) - head.byte_index[2:0];
      sh   = head.little_endian ? lane : 3'(hn - 4'd1 - {1'b0, lane});
      bank_row[b] = ROW_W'(head.byte_index >> 3) +
                    ROW_W'(3'(b) < head.byte_index[2:0]);
      if (state == S_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_row;
        bank_wdata[b] = 8'd0;
      end else begin
        bank_we[b]    = pop && head.is_write && !head.refused && ({1'b0, lane} < hn);
        bank_waddr[b] = bank_row[b];
        bank_wdata[b] = 8'(head.raw >> {sh, 3'b000});
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_bank
    teba_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (bank_waddr[g]),
      .wdata (bank_wdata[g]),
      .raddr (bank_row[g]),
      .rdata (bank_rdata[g])
    );
  end

  // gather bytes, split sign and magnitude, count leading zeros
  always_comb begin
    logic [32:0] sx;
    asm_raw = '0;
    for (int i = 0; i < LANES; i++) begin
      logic [2:0] sh;
      sh = op.little_endian ? 3'(i) : 3'(on - 4'd1 - 4'(i));
      if (4'(i) < on) begin
        asm_raw = asm_raw |
                  ({56'd0, bank_rdata[3'(op.byte_index[2:0] + 3'(i))]} << {sh, 3'b000});
      end
    end
    sx       = '0;
    asm_sign = 1'b0;
    asm_mag  = '0;
    case (op.elem_type) inside
      ET_U8, ET_U8C, ET_U16, ET_U32: asm_mag = asm_raw[31:0];
      ET_I8:  sx = {{25{asm_raw[7]}}, asm_raw[7:0]};
      ET_I16: sx = {{17{asm_raw[15]}}, asm_raw[15:0]};
      ET_I32: sx = {asm_raw[31], asm_raw[31:0]};
      ET_F32: asm_mag = {asm_raw[22:0], 9'd0};
      default: asm_mag = '0;
    endcase
    if (op.elem_type == ET_I8 || op.elem_type == ET_I16 || op.elem_type == ET_I32) begin
      asm_sign = sx[32];
      asm_mag  = sx[32] ? 32'(33'd0 - sx) : sx[31:0];
    end
    asm_lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (asm_mag[i]) begin
        asm_lz = 5'(31 - i);
      end
    end
  end

  always_comb begin
    norm = rd_mag << rd_lz;
    case (op.elem_type) inside
      ET_U8, ET_U8C, ET_U16, ET_U32, ET_I8, ET_I16, ET_I32: begin
        if (rd_mag == '0) begin
          conv = '0;
        end else begin
          conv = {rd_sign, 11'(11'd1054 - {6'd0, rd_lz}), norm[30:0], 21'd0};
        end
      end
      ET_F32: begin
        if (rd_raw[30:23] == 8'hFF) begin
          conv = (rd_raw[22:0] != '0) ? CANON_NAN : {rd_raw[31], 11'h7FF, 52'd0};
        end else if (rd_raw[30:23] == 8'd0) begin
          if (rd_raw[22:0] == '0) begin
            conv = {rd_raw[31], 63'd0};
          end else begin
            conv = {rd_raw[31], 11'(11'd896 - {6'd0, rd_lz}), norm[30:9], 30'd0};
          end
        end else begin
          conv = {rd_raw[31], 11'({3'd0, rd_raw[30:23]} + 11'd896), rd_raw[22:0], 29'd0};
        end
      end
      ET_F64: begin
        conv = (rd_raw[62:52] == 11'h7FF && rd_raw[51:0] != '0) ? CANON_NAN : rd_raw;
      end
      ET_I64, ET_U64: conv = rd_raw;
      default:        conv = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= head;
    end
    if (state == S_READ) begin
      rd_raw  <= asm_raw;
      rd_sign <= asm_sign;
      rd_mag  <= asm_mag;
      rd_lz   <= asm_lz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_row   <= '0;
      out_valid <= 1'b0;
      out_data  <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_row <= clr_row + 1'b1;
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            if (head.refused || head.is_write) begin
              out_valid            <= 1'b1;
              out_data.read_bits   <= '0;
              out_data.range_error <= head.refused;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_CONV;
        end
        S_CONV: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.read_bits   <= conv;
            out_data.range_error <= 1'b0;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_room: assert property (@(posedge clk) disable iff (rst) pop |-> out_free)
    else $error("pop without output room");
  a_read_conv: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_CONV))
    else $error("read data not converted");
  a_conv_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV && !out_free) |=> (state == S_CONV))
    else $error("conversion result dropped");
endmodule

// ----- rtl/typed_element_buffer_access_core.sv -----
// Typed element load/store over a byte store cleared at reset. After reset the store is
// swept to zero one 8-byte row per cycle, and no access is taken during that sweep.
// Accesses enter a two-entry queue after a bounds and type check and the write value
// conversion. In the back end a write or a refused access is answered into the output
// register when it is popped; a read goes through queue pop with the bank read, byte
// gather with sign split and leading-zero count, then the conversion to double bits
// into the output register, held while the output stalls. The store is eight byte-wide
// banks so that any unaligned element of up to eight bytes is one row access per bank.
// depends on teba_pkg, teba_front, teba_fifo, teba_back
module typed_element_buffer_access_core #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  teba_pkg::teba_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output teba_pkg::teba_out_t out_data
);
  import teba_pkg::*;

  teba_op_t op;
  teba_op_t head;
  logic     empty;
  logic     full;
  logic     pop;
  logic     clearing;

  assign in_stall = full || clearing;

  teba_front #(.STORE_BYTES(STORE_BYTES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .op        (op)
  );

  teba_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !in_stall),
    .push_data (op),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  teba_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

// ----- verif/tb.sv -----
// self-checking testbench for typed_element_buffer_access_core: typed reads and writes,
// byte order, bounds, value conversions; depends on rtl/teba_pkg.sv and the core rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import teba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MEM_BYTES = 4096;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] NEG_INF = 64'hFFF0_0000_0000_0000;
  localparam logic       OP_READ  = 1'b0;
  localparam logic       OP_WRITE = 1'b1;

  class access_scoreboard;
    logic [7:0] mem [MEM_BYTES];
    int unsigned length_reg;
    teba_out_t expected_results[$];
    int mismatches;
    int matched;
    int refused_seen;

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      length_reg = MEM_BYTES;
      mismatches = 0;
      matched = 0;
      refused_seen = 0;
    endfunction

    function int unsigned size_of(logic [3:0] t);
      case (t)
        ET_U8, ET_U8C, ET_I8: return 1;
        ET_U16, ET_I16: return 2;
        ET_U32, ET_I32, ET_F32: return 4;
        default: return 8;
      endcase
    endfunction

    // truncate toward zero, wrap modulo 2^64; nan and inf give zero
    function logic [63:0] to_wrapped(logic [63:0] b);
      int e;
      logic [63:0] m, v;
      if (b[62:52] == 11'h7FF || b[62:52] < 11'd1023) return 64'd0;
      e = int'(b[62:52]) - 1023;
      m = {11'd0, 1'b1, b[51:0]};
      if (e <= 52) v = m >> (52 - e);
      else if (e - 52 >= 64) v = 64'd0;
      else v = m << (e - 52);
      if (b[63]) v = -v;
      return v;
    endfunction

    function logic [7:0] to_clamped(logic [63:0] b);
      int e, s;
      logic [63:0] m, q, rem, half;
      if (b[62:52] == 11'h7FF && b[51:0] != 0) return 8'd0;
      if (b[63]) return 8'd0;
      if (b[62:52] >= 11'd1031) return 8'd255;
      if (b[62:52] < 11'd1022) return 8'd0;
      e = int'(b[62:52]) - 1023;
      s = 52 - e;
      m = {11'd0, 1'b1, b[51:0]};
      q = m >> s;
      rem = m & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      return (q > 64'd255) ? 8'd255 : q[7:0];
    endfunction

    function logic [31:0] to_single(logic [63:0] b);
      logic [31:0] sgn, r;
      logic [63:0] m, q, rem, half;
      int e, s;
      sgn = {b[63], 31'd0};
      if (b[62:52] == 11'h7FF) begin
        if (b[51:0] == 0) return sgn | 32'h7F80_0000;
        return sgn | 32'h7FC0_0000 | 32'(b[51:0] >> 29);
      end
      if (b[62:52] == 0) return sgn;
      e = int'(b[62:52]) - 1023;
      if (e > 127) return sgn | 32'h7F80_0000;
      m = {11'd0, 1'b1, b[51:0]};
      s = (e >= -126) ? 29 : 29 + (-126 - e);
      if (s > 63) return sgn;
      q = m >> s;
      rem = m & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (e >= -126) r = (32'(e + 126) << 23) + q[31:0];
      else r = q[31:0];
      if (r >= 32'h7F80_0000) r = 32'h7F80_0000;
      return sgn | r;
    endfunction

    function logic [63:0] single_to_double(logic [31:0] f);
      logic [63:0] sgn;
      int p;
      sgn = {f[31], 63'd0};
      if (f[30:23] == 8'hFF) return (f[22:0] != 0) ? CANON_NAN : (sgn | POS_INF);
      if (f[30:23] == 0) begin
        if (f[22:0] == 0) return sgn;
        p = 22;
        while (!f[p]) p--;
        return sgn | (64'(p - 149 + 1023) << 52) |
               ((64'(f[22:0]) << (52 - p)) & 64'h000F_FFFF_FFFF_FFFF);
      end
      return sgn | (64'(int'(f[30:23]) - 127 + 1023) << 52) | (64'(f[22:0]) << 29);
    endfunction

    function logic [63:0] int_bits(longint v);
      return $realtobits(real'(v));
    endfunction

    function void set_length(logic [12:0] v);
      length_reg = v;
    endfunction

    function void note_access(teba_in_t a);
      teba_out_t r;
      int unsigned n, lim, sh;
      logic [63:0] raw;
      r = '0;
      raw = 64'd0;
      lim = (length_reg < MEM_BYTES) ? length_reg : MEM_BYTES;
      n = size_of(a.elem_type);
      if (a.elem_type > ET_U64 || int'(a.byte_index) + n > lim) begin
        r.range_error = 1'b1;
        refused_seen++;
      end else if (a.mode == OP_WRITE) begin
        case (a.elem_type)
          ET_U8C: raw = 64'(to_clamped(a.write_bits));
          ET_F32: raw = 64'(to_single(a.write_bits));
          ET_F64, ET_I64, ET_U64: raw = a.write_bits;
          default: raw = to_wrapped(a.write_bits);
        endcase
        for (int i = 0; i < n; i++) begin
          sh = a.little_endian ? i : n - 1 - i;
          mem[a.byte_index + i] = raw[8*sh +: 8];
        end
      end else begin
        for (int i = 0; i < n; i++) begin
          sh = a.little_endian ? i : n - 1 - i;
          raw[8*sh +: 8] = mem[a.byte_index + i];
        end
        case (a.elem_type)
          ET_U8, ET_U8C, ET_U16, ET_U32: r.read_bits = int_bits(longint'(raw));
          ET_I8: r.read_bits = int_bits(longint'({{56{raw[7]}}, raw[7:0]}));
          ET_I16: r.read_bits = int_bits(longint'({{48{raw[15]}}, raw[15:0]}));
          ET_I32: r.read_bits = int_bits(longint'({{32{raw[31]}}, raw[31:0]}));
          ET_F32: r.read_bits = single_to_double(raw[31:0]);
          ET_F64: r.read_bits = (raw[62:52] == 11'h7FF && raw[51:0] != 0) ? CANON_NAN : raw;
          default: r.read_bits = raw;
        endcase
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(teba_out_t got);
      teba_out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", got.read_bits, got.range_error);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_bits !== want.read_bits || got.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected bits %h err %b, got bits %h err %b",
                   want.read_bits, want.range_error, got.read_bits, got.range_error);
      end else begin
        matched++;
      end
    endfunction
  endclass

  logic clk, rst, cfg_we;
  logic [12:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  teba_in_t in_data;
  teba_out_t out_data;

  access_scoreboard sb;
  int cycles;
  int hold_cycles;
  bit idle_enable;
  int accepted_items;

  typed_element_buffer_access_core uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= idle_enable && ($urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
  end

  task automatic send_access(teba_in_t a);
    int gap;
    if (idle_enable && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= a;
    do @(posedge clk); while (in_stall);
    sb.note_access(a);
    accepted_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_length(logic [12:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_length(v);
  endtask

  function automatic teba_in_t make_access(logic m, logic [3:0] t, logic le,
                                           logic [11:0] idx, logic [63:0] wb);
    teba_in_t a;
    a.mode = m;
    a.elem_type = t;
    a.little_endian = le;
    a.byte_index = idx;
    a.write_bits = wb;
    return a;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] specials [14];
    logic [63:0] v;
    specials = '{POS_INF, NEG_INF, CANON_NAN, 64'h7FF0_0000_0000_0001, 64'hFFF8_1234_5678_9ABC,
                 64'h0, 64'h8000_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                 64'h0000_0000_0000_0001, 64'h36A0_0000_0000_0000, 64'h47EF_FFFF_E000_0000,
                 64'h47EF_FFFF_F000_0000, 64'h406F_F000_0000_0000, 64'h4070_0000_0000_0000};
    case ($urandom_range(0, 5))
      0: v = {$urandom, $urandom};
      1: v = $realtobits(real'($signed($urandom_range(0, 1200)) - 600));
      2: v = $realtobits(real'(int'($urandom_range(0, 600)) - 40) / 2.0);
      3: v = specials[$urandom_range(0, 13)];
      4: v = {1'($urandom), 11'($urandom_range(1015, 1090)), $urandom, 20'($urandom)};
      default: v = {1'($urandom), 11'($urandom_range(850, 1160)), $urandom, 20'($urandom)};
    endcase
    return v;
  endfunction

  function automatic teba_in_t random_access();
    logic [3:0] t;
    logic [11:0] idx;
    int unsigned lim;
    lim = (sb.length_reg < MEM_BYTES) ? sb.length_reg : MEM_BYTES;
    t = ($urandom_range(0, 99) < 5) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    case ($urandom_range(0, 19))
      0, 1, 2: idx = 12'($urandom);
      3, 4, 5: idx = 12'((lim > 10 ? lim : 10) - $urandom_range(0, 10));
      default: idx = 12'($urandom_range(0, 40));
    endcase
    return make_access(1'($urandom), t, 1'($urandom), idx,
                       (t == ET_I64 || t == ET_U64) ? {$urandom, $urandom} : pick_value());
  endfunction

  task automatic run_random(int count);
    repeat (count) send_access(random_access());
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_cycles = 0;
    idle_enable = 1'b1;
    accepted_items = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_length(13'd4096);
    // directed: extremes per type, both byte orders, special values, refusals
    send_access(make_access(OP_WRITE, ET_U8, 1'b1, 12'd0, $realtobits(-1.0)));
    send_access(make_access(OP_READ, ET_I8, 1'b1, 12'd0, '0));
    send_access(make_access(OP_WRITE, ET_U8C, 1'b1, 12'd1, $realtobits(2.5)));
    send_access(make_access(OP_WRITE, ET_U8C, 1'b1, 12'd2, $realtobits(3.5)));
    send_access(make_access(OP_READ, ET_U16, 1'b0, 12'd1, '0));
    send_access(make_access(OP_WRITE, ET_U8C, 1'b0, 12'd3, CANON_NAN));
    send_access(make_access(OP_WRITE, ET_I16, 1'b0, 12'd4, $realtobits(-32768.0)));
    send_access(make_access(OP_READ, ET_I16, 1'b1, 12'd4, '0));
    send_access(make_access(OP_WRITE, ET_U32, 1'b1, 12'd8, $realtobits(4294967296.0 + 7.0)));
    send_access(make_access(OP_WRITE, ET_I32, 1'b0, 12'd12, NEG_INF));
    send_access(make_access(OP_READ, ET_U32, 1'b1, 12'd9, '0));
    send_access(make_access(OP_WRITE, ET_F32, 1'b1, 12'd16, 64'h7FF0_0000_0000_0001));
    send_access(make_access(OP_READ, ET_F32, 1'b1, 12'd16, '0));
    send_access(make_access(OP_WRITE, ET_F32, 1'b0, 12'd20, 64'h47EF_FFFF_F000_0000));
    send_access(make_access(OP_WRITE, ET_F32, 1'b1, 12'd24, 64'h36A0_0000_0000_0000));
    send_access(make_access(OP_READ, ET_F32, 1'b0, 12'd20, '0));
    send_access(make_access(OP_WRITE, ET_F64, 1'b0, 12'd28, 64'hFFF8_0000_DEAD_BEEF));
    send_access(make_access(OP_READ, ET_F64, 1'b0, 12'd28, '0));
    send_access(make_access(OP_WRITE, ET_I64, 1'b1, 12'd36, 64'hFFFF_FFFF_FFFF_FFFF));
    send_access(make_access(OP_READ, ET_U64, 1'b0, 12'd35, '0));
    send_access(make_access(OP_READ, ET_F64, 1'b1, 12'd4088, '0));
    send_access(make_access(OP_WRITE, ET_F64, 1'b1, 12'd4089, POS_INF));
    send_access(make_access(OP_READ, 4'd15, 1'b1, 12'd4095, '0));
    send_access(make_access(OP_READ, ET_U8, 1'b1, 12'd4095, '0));

    run_random(350);

    // long receiver hold-off while items keep coming
    hold_cycles <= 300;
    run_random(150);
    write_length(13'd0);
    run_random(60);
    write_length(13'd8191);
    idle_enable = 1'b0;
    run_random(400);
    idle_enable = 1'b1;
    write_length(13'd37);
    run_random(300);
    write_length(13'd4095);
    run_random(350);
    write_length(13'd4096);
    run_random(300);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("%0d accesses sent, %0d results matched, %0d refused, length settings 0..8191",
             accepted_items, sb.matched, sb.refused_seen);
    $display("%0d mismatches, %0d results still outstanding",
             sb.mismatches, sb.expected_results.size());
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- typed_element_buffer_access_core.f -----
rtl/teba_pkg.sv
rtl/teba_ram.sv
rtl/teba_fifo.sv
rtl/teba_front.sv
rtl/teba_back.sv
rtl/typed_element_buffer_access_core.sv
verif/tb.sv
